/* src/ddl_pkg.sv */
// Shared types, constants and helpers of the decimal digit list store.
package ddl_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int RADIX       = 10;

	localparam int MODE_W = 4;
	localparam int DIG_W  = 4;
	localparam int POS_W  = 5;
	localparam int FAC_W  = 31;
	localparam int ST_W   = 3;
	localparam int N_W    = 4;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int RC_W   = $clog2(DEPTH);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int SUM_W  = ((CNT_W > N_W) ? CNT_W : N_W) + 1;
	localparam int NPOW   = 9;

	localparam logic [MODE_W-1:0] MODE_FRONT  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_END    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_BEFORE = 4'd2;
	localparam logic [MODE_W-1:0] MODE_AFTER  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_DELETE = 4'd4;
	localparam logic [MODE_W-1:0] MODE_MUL    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_DIV    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_READ   = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 4'd8;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [ST_W-1:0] ST_BADDIGIT = 3'd4;

	localparam logic [DIG_W-1:0] MAX_DIGIT = DIG_W'(RADIX - 1);

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_FROM_LEFT,
		OP_FROM_RIGHT
	} cell_op_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_DELETE,
		CMD_FILL,
		CMD_ROTATE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
		logic [DIG_W-1:0] digit;
	} chain_cmd_t;

	localparam logic [FAC_W-1:0] POW10 [NPOW] = '{
		31'd10, 31'd100, 31'd1000, 31'd10000, 31'd100000,
		31'd1000000, 31'd10000000, 31'd100000000, 31'd1000000000
	};

	function automatic logic [N_W-1:0] extra_digits(input logic [FAC_W-1:0] f);
		logic [N_W-1:0] n;
		n = '0;
		for (int k = 0; k < NPOW; k++) begin
			if (f >= POW10[k])
				n = n + N_W'(1);
		end
		return n;
	endfunction

endpackage

/* src/ddl_cell.sv */
// One list cell: holds a digit and takes it from a neighbor or a load value.
module ddl_cell import ddl_pkg::*; (
	input  logic             clk,
	input  cell_op_t         op,
	input  logic [DIG_W-1:0] left_d,
	input  logic [DIG_W-1:0] right_d,
	input  logic [DIG_W-1:0] load_d,
	output logic [DIG_W-1:0] d
);

	logic [DIG_W-1:0] d_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD:       d_q <= load_d;
			OP_FROM_LEFT:  d_q <= left_d;
			OP_FROM_RIGHT: d_q <= right_d;
			default:       d_q <= d_q;
		endcase
	end

	assign d = d_q;

endmodule

/* src/ddl_chain.sv */
// Ring of digit cells with per-cell shift, load and rotate decode.
module ddl_chain import ddl_pkg::*; (
	input  logic             clk,
	input  chain_cmd_t       cmd,
	output logic [DIG_W-1:0] head
);

	logic [DIG_W-1:0] d [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		cell_op_t op;

		always_comb begin
			op = OP_HOLD;
			case (cmd.kind)
				CMD_INSERT: begin
					if (IDX == cmd.lo)
						op = OP_LOAD;
					else if (IDX > cmd.lo)
						op = OP_FROM_LEFT;
				end
				CMD_DELETE: begin
					if (IDX >= cmd.lo)
						op = OP_FROM_RIGHT;
				end
				CMD_FILL: begin
					if (IDX >= cmd.lo && IDX < cmd.hi)
						op = OP_LOAD;
				end
				CMD_ROTATE: op = OP_FROM_RIGHT;
				default:    op = OP_HOLD;
			endcase
		end

		ddl_cell u_cell (
			.clk     (clk),
			.op      (op),
			.left_d  (d[(i + DEPTH - 1) % DEPTH]),
			.right_d (d[(i + 1) % DEPTH]),
			.load_d  (cmd.digit),
			.d       (d[i])
		);
	end

	assign head = d[0];

endmodule

/* src/decimal_digit_list_store.sv */
// Top level: command capture, list operation sequencer and result strobe.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | mode, digit, position, factor
//  result   | valid (one cycle)  | digit_out, list_length, status, last
//
// A non-read operation, or a read of an empty list, runs capture, then execute with one result.
// A read of a non-empty list runs capture and execute, then the ring rotates once through all
// cells, one digit a cycle from the head cell up to the list length, and ends back in list order.
// Reset clears the digit count and the sequencer; cell contents stay as is.
// The receiver cannot stall: each result is on the ports for one cycle.
module decimal_digit_list_store import ddl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [MODE_W-1:0] mode,
	input  logic [DIG_W-1:0]  digit,
	input  logic [POS_W-1:0]  position,
	input  logic [FAC_W-1:0]  factor,
	output logic              valid,
	output logic [DIG_W-1:0]  digit_out,
	output logic [CNT_W-1:0]  list_length,
	output logic [ST_W-1:0]   status,
	output logic              last
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_READ = 3'b100
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RC_W-1:0]   rcnt_q;
	logic [MODE_W-1:0] mode_q;
	logic [DIG_W-1:0]  digit_q;
	logic [POS_W-1:0]  pos_q;
	logic [N_W-1:0]    n_q;

	chain_cmd_t        cmd;
	logic [DIG_W-1:0]  head;
	logic [CNT_W-1:0]  cnt_nx;
	logic [ST_W-1:0]   st_c;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  cnt_c;
	logic [SUM_W-1:0]  sum_c;
	logic              pos_bad;
	logic              emit_rd;
	logic              last_rd;
	logic              accept;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign pos_c   = CMP_W'(pos_q);
	assign cnt_c   = CMP_W'(cnt_q);
	assign pos_bad = (pos_c == '0) || (pos_c > cnt_c);
	assign emit_rd = (int'(rcnt_q) < int'(cnt_q)) && (int'(rcnt_q) < MAX_RESULTS);
	assign last_rd = (int'(rcnt_q) + 1 == int'(cnt_q)) || (int'(rcnt_q) + 1 == MAX_RESULTS);

	always_comb begin
		cmd       = '{kind: CMD_NONE, lo: '0, hi: '0, digit: digit_q};
		cnt_nx    = cnt_q;
		st_c      = ST_OK;
		sum_c     = '0;
		if (state_q == S_EXEC) begin
			case (mode_q)
				MODE_FRONT, MODE_END, MODE_BEFORE, MODE_AFTER: begin
					if (digit_q > MAX_DIGIT) begin
						st_c = ST_BADDIGIT;
					end else if (int'(cnt_q) >= DEPTH) begin
						st_c = ST_FULL;
					end else if (mode_q == MODE_FRONT) begin
						cmd.kind = CMD_INSERT;
						cmd.lo   = '0;
					end else if (mode_q == MODE_END) begin
						cmd.kind = CMD_INSERT;
						cmd.lo   = cnt_q;
					end else if (pos_bad) begin
						st_c = ST_BADPOS;
					end else if (mode_q == MODE_BEFORE) begin
						cmd.kind = CMD_INSERT;
						cmd.lo   = CNT_W'(pos_c - CMP_W'(1));
					end else begin
						cmd.kind = CMD_INSERT;
						cmd.lo   = CNT_W'(pos_c);
					end
					if (cmd.kind == CMD_INSERT)
						cnt_nx = cnt_q + CNT_W'(1);
				end
				MODE_DELETE: begin
					if (cnt_q == '0) begin
						st_c = ST_EMPTY;
					end else if (pos_bad) begin
						st_c = ST_BADPOS;
					end else begin
						cmd.kind = CMD_DELETE;
						cmd.lo   = CNT_W'(pos_c - CMP_W'(1));
						cnt_nx   = cnt_q - CNT_W'(1);
					end
				end
				MODE_MUL: begin
					sum_c     = SUM_W'(cnt_q) + SUM_W'(n_q);
					cmd.kind  = CMD_FILL;
					cmd.lo    = cnt_q;
					cmd.digit = '0;
					if (int'(sum_c) > DEPTH) begin
						st_c   = ST_FULL;
						cnt_nx = CNT_W'(DEPTH);
					end else begin
						cnt_nx = CNT_W'(sum_c);
					end
					cmd.hi = cnt_nx;
				end
				MODE_DIV: begin
					if (SUM_W'(n_q) > SUM_W'(cnt_q)) begin
						st_c   = ST_EMPTY;
						cnt_nx = '0;
					end else begin
						cnt_nx = CNT_W'(SUM_W'(cnt_q) - SUM_W'(n_q));
					end
				end
				MODE_READ: begin
					if (cnt_q == '0)
						st_c = ST_EMPTY;
				end
				MODE_CLEAR: cnt_nx = '0;
				default:    st_c = ST_OK;
			endcase
		end else if (state_q == S_READ) begin
			cmd.kind = CMD_ROTATE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rcnt_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					cnt_q  <= cnt_nx;
					rcnt_q <= '0;
					if (mode_q == MODE_READ && cnt_q != '0)
						state_q <= S_READ;
					else
						state_q <= S_IDLE;
				end
				S_READ: begin
					rcnt_q <= rcnt_q + RC_W'(1);
					if (rcnt_q == RC_W'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			digit_q <= digit;
			pos_q   <= position;
			n_q     <= extra_digits(factor);
		end
	end

	ddl_chain u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.head (head)
	);

	always_comb begin
		valid       = 1'b0;
		digit_out   = '0;
		list_length = cnt_q;
		status      = ST_OK;
		last        = 1'b0;
		if (state_q == S_EXEC && !(mode_q == MODE_READ && cnt_q != '0)) begin
			valid       = 1'b1;
			list_length = cnt_nx;
			status      = st_c;
			last        = 1'b1;
		end else if (state_q == S_READ && emit_rd) begin
			valid     = 1'b1;
			digit_out = head;
			last      = last_rd;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= DEPTH)
		else $error("digit count beyond depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && state_q == S_EXEC)
		else $error("accepted command did not start execution");

	a_exec_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && state_q == S_EXEC) |=> !busy)
		else $error("single result not followed by idle");

	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> $stable(cnt_q))
		else $error("digit count changed during read out");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && state_q == S_READ) |-> (status == ST_OK && digit_out <= MAX_DIGIT))
		else $error("read out transfer with bad status or digit");

endmodule
